FILE: hdl/cea_pkg.sv
// Shared types and constants for the channel energy accumulator.
// Holds the word structs, register indexes and datapath widths; depends on nothing.
package cea_pkg;

  localparam int unsigned CH_SLOTS         = 8;
  localparam int unsigned NUM_CHANNELS_DEF = 8;

  localparam int unsigned TICK_W     = 32;
  localparam int unsigned PERIOD_W   = 10;
  localparam int unsigned WATT_W     = 16;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned SRC_W      = 4;
  localparam int unsigned ENERGY_W   = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Digit-serial multiplier: a 42-bit multiplicand (elapsed milliseconds) times a
  // 16-bit multiplier taken four bits per step.
  localparam int unsigned MCAND_W   = TICK_W + PERIOD_W;
  localparam int unsigned MPLR_W    = 16;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned PROD_W    = MCAND_W + MPLR_W;
  localparam int unsigned MUL_STEPS = MPLR_W / DIGIT_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

  localparam logic [SRC_W-1:0] SYSTEM_SOURCE = 4'd8;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 10'd1;
  localparam logic [TICK_W-1:0]   INTERVAL_RST    = 32'd300000;
  localparam logic [WATT_W-1:0]   BASELINE_RST    = 16'd0;
  localparam logic [MASK_W-1:0]   ENABLE_RST      = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_INTERVAL    = 2'd1,
    CFG_BASELINE    = 2'd2,
    CFG_ENABLE_MASK = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FUNC_START  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef struct packed {
    logic              func;
    logic [TICK_W-1:0] tick_count;
    logic [WATT_W-1:0] power_ch0;
    logic [WATT_W-1:0] power_ch1;
    logic [WATT_W-1:0] power_ch2;
    logic [WATT_W-1:0] power_ch3;
    logic [WATT_W-1:0] power_ch4;
    logic [WATT_W-1:0] power_ch5;
    logic [WATT_W-1:0] power_ch6;
    logic [WATT_W-1:0] power_ch7;
  } in_word_t;

  typedef struct packed {
    logic [SRC_W-1:0]    source;
    logic [ENERGY_W-1:0] energy_wms;
    logic                last_result;
  } out_word_t;

  // Update request from the sequencer to the accumulator bank.
  typedef struct packed {
    logic             upd;
    logic [SRC_W-1:0] idx;
    logic             set_pending;
    logic             clr_pending;
  } bank_ctrl_t;

endpackage

FILE: hdl/cea_digit_mul.sv
// Digit-serial multiplier, four multiplier bits per cycle.
// Uses widths from cea_pkg.
module cea_digit_mul
  import cea_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MCAND_W-1:0] a_i,
  input  logic [MPLR_W-1:0]  b_i,
  output logic              done_o,
  output logic [PROD_W-1:0]  product_o
);

  localparam int unsigned SUM_W = MCAND_W + DIGIT_W;

  logic [MCAND_W-1:0]   a_q;
  logic [MCAND_W-1:0]   hi_q, hi_d;
  logic [MPLR_W-1:0]    lo_q, lo_d;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [SUM_W-1:0]     partial, sum;

  // Each step adds one partial product and shifts a finished digit into the low half.
  assign partial = SUM_W'(a_q) * SUM_W'(lo_q[DIGIT_W-1:0]);
  assign sum     = SUM_W'(hi_q) + partial;
  assign hi_d    = sum[SUM_W-1:DIGIT_W];
  assign lo_d    = {sum[DIGIT_W-1:0], lo_q[MPLR_W-1:DIGIT_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

FILE: hdl/cea_energy_bank.sv
// Saturating energy accumulators for the channels and the system total.
// Uses types and widths from cea_pkg.
module cea_energy_bank
  import cea_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bank_ctrl_t              ctrl_i,
  input  logic [PROD_W-1:0]       addend_i,
  output logic [ENERGY_W-1:0]     energy_o,
  output logic [NUM_CHANNELS-1:0] pending_o
);

  localparam int unsigned DEPTH = NUM_CHANNELS + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [ENERGY_W-1:0]     energy_q [DEPTH];
  logic [NUM_CHANNELS-1:0] pending_q;
  logic [IDX_W-1:0]        idx;
  logic [ENERGY_W:0]       sum;
  logic [ENERGY_W-1:0]     sat_sum;

  assign idx      = ctrl_i.idx[IDX_W-1:0];
  assign energy_o = energy_q[idx];
  assign sum      = (ENERGY_W + 1)'(energy_q[idx]) + (ENERGY_W + 1)'(addend_i);
  // A carry out means the total passed the top of the range: pin it there.
  assign sat_sum  = sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < DEPTH; e++) begin
        energy_q[e] <= '0;
      end
      pending_q <= '0;
    end else if (ctrl_i.upd) begin
      for (int e = 0; e < DEPTH; e++) begin
        if (idx == IDX_W'(e)) begin
          energy_q[e] <= sat_sum;
        end
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (idx == IDX_W'(c)) begin
          if (ctrl_i.clr_pending) begin
            pending_q[c] <= 1'b0;
          end else if (ctrl_i.set_pending) begin
            pending_q[c] <= 1'b1;
          end
        end
      end
    end
  end

  assign pending_o = pending_q;

endmodule

FILE: hdl/channel_energy_accumulator.sv
// Top level of the channel energy accumulator: sequencer, tick registers,
// configuration registers and output register. Uses cea_pkg, cea_digit_mul, cea_energy_bank.
//
// Usage: an input word on in_word_i is taken when in_valid_i is high and
// in_stall_o is low. A start word only records its tick count and back-dates
// the publish timer; it gives no output and the block is ready again in the
// next cycle. A sample word is worked on alone: in_stall_o stays high until
// every report it causes has been handed to the output register.
// Each sample first turns the elapsed ticks into milliseconds, then visits
// every channel and the system total in turn through one shared multiplier
// that takes four bits of the watt figure per cycle. The multiplier sets the
// pace: a multiply for the elapsed time, then a multiply and an update for
// each source, and an emit step for each reported word.
// Reports leave through out_word_o with out_valid_o, channels in ascending
// order and the system total last; the final word of a sample has last_result
// set. A stalled output word holds steady, and the block waits only when it
// has a further word and the output register is still full.
// Configuration writes on the cfg port are always taken (cfg_ready_o is high)
// and are meant to be made while the block is idle. Reset clears every
// accumulator, pending flag and tick register and loads the register defaults.
module channel_energy_accumulator
  import cea_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = NUM_CHANNELS + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ELAPSED = 5'b00010,
    ST_MUL     = 5'b00100,
    ST_UPDATE  = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [PERIOD_W-1:0] tick_period_q;
  logic [TICK_W-1:0]   interval_q;
  logic [WATT_W-1:0]   baseline_q;
  logic [MASK_W-1:0]   enable_q;

  // Tick bookkeeping.
  logic [TICK_W-1:0] prev_tick_q;
  logic [TICK_W-1:0] prev_pub_q;

  // Per-sample working registers.
  logic [WATT_W-1:0]  pwr_q [NUM_CHANNELS];
  logic [DEPTH-1:0]   report_q;
  logic [MCAND_W-1:0] em_q;
  logic [IDX_W-1:0]   idx_q, idx_d;

  logic               out_valid_q;
  out_word_t          out_word_q;

  logic [WATT_W-1:0]       in_pwr [CH_SLOTS];
  logic                    in_accept, is_sample, due;
  logic [TICK_W-1:0]       elapsed_ticks;
  logic [DEPTH-1:0]        report_mask;
  logic [NUM_CHANNELS-1:0] pending;
  logic [WATT_W-1:0]       cur_watts, nxt_watts;
  logic                    idx_is_sys, more_reports, out_free, out_load, advance;

  logic               mul_start, mul_done;
  logic [MCAND_W-1:0] mul_a;
  logic [MPLR_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_product;

  bank_ctrl_t          bank_ctrl;
  logic [ENERGY_W-1:0] bank_energy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TICK_PERIOD_RST;
      interval_q    <= INTERVAL_RST;
      baseline_q    <= BASELINE_RST;
      enable_q      <= ENABLE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TICK_PERIOD: tick_period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_INTERVAL:    interval_q    <= cfg_data_i[TICK_W-1:0];
        CFG_BASELINE:    baseline_q    <= cfg_data_i[WATT_W-1:0];
        CFG_ENABLE_MASK: enable_q      <= cfg_data_i[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input side. Only an idle block takes a word.
  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign is_sample     = (in_word_i.func == FUNC_SAMPLE);
  assign elapsed_ticks = in_word_i.tick_count - prev_tick_q;
  assign due           = (in_word_i.tick_count - prev_pub_q) >= interval_q;

  assign in_pwr[0] = in_word_i.power_ch0;
  assign in_pwr[1] = in_word_i.power_ch1;
  assign in_pwr[2] = in_word_i.power_ch2;
  assign in_pwr[3] = in_word_i.power_ch3;
  assign in_pwr[4] = in_word_i.power_ch4;
  assign in_pwr[5] = in_word_i.power_ch5;
  assign in_pwr[6] = in_word_i.power_ch6;
  assign in_pwr[7] = in_word_i.power_ch7;

  // Which sources will report is known when the sample arrives: a drawing
  // channel reports when the interval is due, an idle one when it still holds
  // an unreported change. This also tells which report is the last.
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (enable_q[c] && (in_pwr[c] != '0)) begin
        report_mask[c] = due;
      end else begin
        report_mask[c] = pending[c];
      end
    end
    report_mask[NUM_CHANNELS] = (baseline_q != '0) && due;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tick_q <= '0;
      prev_pub_q  <= '0;
    end else if (in_accept) begin
      prev_tick_q <= in_word_i.tick_count;
      if (!is_sample) begin
        prev_pub_q <= in_word_i.tick_count - interval_q;
      end else if (due) begin
        prev_pub_q <= in_word_i.tick_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && is_sample) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pwr_q[c] <= enable_q[c] ? in_pwr[c] : '0;
      end
      report_q <= report_mask;
    end
    if (state_q == ST_ELAPSED && mul_done) begin
      em_q <= mul_product[MCAND_W-1:0];
    end
  end

  // Source selection: channels first, the system baseline at the last index.
  assign idx_is_sys = (idx_q == IDX_W'(NUM_CHANNELS));

  always_comb begin
    cur_watts = baseline_q;
    nxt_watts = baseline_q;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (idx_q == IDX_W'(c)) begin
        cur_watts = pwr_q[c];
      end
      if (idx_d == IDX_W'(c)) begin
        nxt_watts = pwr_q[c];
      end
    end
  end

  always_comb begin
    more_reports = 1'b0;
    for (int j = 0; j < DEPTH; j++) begin
      if ((IDX_W'(j) > idx_q) && report_q[j]) begin
        more_reports = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    mul_start = 1'b0;
    mul_a     = em_q;
    mul_b     = nxt_watts;
    out_load  = 1'b0;
    advance   = 1'b0;
    bank_ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        mul_a = MCAND_W'(elapsed_ticks);
        mul_b = MPLR_W'(tick_period_q);
        if (in_accept && is_sample) begin
          mul_start = 1'b1;
          state_d   = ST_ELAPSED;
        end
      end
      ST_ELAPSED: begin
        mul_a = mul_product[MCAND_W-1:0];
        idx_d = '0;
        if (mul_done) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        bank_ctrl.upd         = 1'b1;
        bank_ctrl.idx         = SRC_W'(idx_q);
        bank_ctrl.set_pending = (cur_watts != '0);
        bank_ctrl.clr_pending = report_q[idx_q];
        if (report_q[idx_q]) begin
          state_d = ST_EMIT;
        end else begin
          advance = 1'b1;
        end
      end
      ST_EMIT: begin
        bank_ctrl.idx = SRC_W'(idx_q);
        if (out_free) begin
          out_load = 1'b1;
          advance  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (advance) begin
      if (idx_is_sys) begin
        state_d = ST_IDLE;
      end else begin
        idx_d     = idx_q + 1'b1;
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  cea_digit_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  cea_energy_bank #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (bank_ctrl),
    .addend_i  (mul_product),
    .energy_o  (bank_energy),
    .pending_o (pending)
  );

  // Output register: a word waits here while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q.source      <= idx_is_sys ? SYSTEM_SOURCE : SRC_W'(idx_q);
      out_word_q.energy_wms  <= bank_energy;
      out_word_q.last_result <= !more_reports;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: tb/channel_energy_accumulator_tb.sv
// Self-checking testbench for the channel energy accumulator.
// It drives start and sample words and checks every energy report against its own model.
// Depends on cea_pkg and on the channel_energy_accumulator module.
module channel_energy_accumulator_tb;
  import cea_pkg::*;

  // Cycles allowed after the last report for any work still inside the block.
  localparam int SETTLE_CYCLES = 120;

  typedef logic [CH_SLOTS-1:0][WATT_W-1:0] watt_vec_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // Input channel, driven by the word driver below.
  logic     in_valid = 1'b0;
  in_word_t in_word  = '0;
  logic     in_stall_o;

  // Output channel, sampled by the report monitor below.
  logic      out_stall = 1'b0;
  logic      out_valid_o;
  out_word_t out_word_o;

  // Register write channel, driven from the stimulus process.
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  cfg_ready_o;

  // Words waiting to be offered to the block, and the reports still owed by it.
  in_word_t  pending_words [$];
  out_word_t report_q [$];

  // Idle behaviour of both sides: chance per cycle, in percent, of starting a burst.
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  int error_count  = 0;

  // The model's copy of the registers, loaded with the reset defaults.
  logic [PERIOD_W-1:0] period_ms = TICK_PERIOD_RST;
  logic [TICK_W-1:0]   interval  = INTERVAL_RST;
  logic [WATT_W-1:0]   base_w    = BASELINE_RST;
  logic [MASK_W-1:0]   en_mask   = ENABLE_RST;

  // The model's copy of the block state: tick marks, accumulators and
  // the flags of channels whose total changed since their last report.
  logic [TICK_W-1:0]   model_tick   = '0;
  logic [TICK_W-1:0]   publish_mark = '0;
  logic [ENERGY_W-1:0] acc_wms [CH_SLOTS];
  logic                unreported [CH_SLOTS];
  logic [ENERGY_W-1:0] sys_wms = '0;

  initial begin
    for (int ch = 0; ch < CH_SLOTS; ch++) begin
      acc_wms[ch]    = '0;
      unreported[ch] = 1'b0;
    end
  end

  channel_energy_accumulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Accumulators saturate at the all-ones value rather than wrapping.
  function automatic logic [ENERGY_W-1:0] sat_sum(logic [ENERGY_W-1:0] a,
                                                  logic [ENERGY_W-1:0] b);
    logic [ENERGY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ENERGY_W] ? '1 : s[ENERGY_W-1:0];
  endfunction

  // Advances the model by one accepted word and queues the reports it causes.
  // A start word only moves the tick marks; the publish mark is set one
  // interval back, so that the first sample after it is due.
  function automatic void integrate_word(in_word_t w);
    watt_vec_t           draw;
    logic [TICK_W-1:0]   dt;
    logic [ENERGY_W-1:0] ms;
    logic [ENERGY_W-1:0] watts;
    logic                due;
    out_word_t           batch [CH_SLOTS+1];
    int                  n;
    n = 0;
    if (w.func == FUNC_START) begin
      model_tick   = w.tick_count;
      publish_mark = w.tick_count - interval;
      return;
    end
    draw = {w.power_ch7, w.power_ch6, w.power_ch5, w.power_ch4,
            w.power_ch3, w.power_ch2, w.power_ch1, w.power_ch0};
    // Elapsed ticks are taken modulo 2^32, so a wrapped counter is harmless.
    dt = w.tick_count - model_tick;
    ms = {32'd0, dt} * {54'd0, period_ms};
    model_tick = w.tick_count;
    due = (w.tick_count - publish_mark) >= interval;
    if (due) begin
      publish_mark = w.tick_count;
    end
    for (int ch = 0; ch < NUM_CHANNELS_DEF; ch++) begin
      // A masked channel draws nothing, but may still owe its report.
      watts = en_mask[ch] ? {48'd0, draw[ch]} : '0;
      if (watts != 0) begin
        acc_wms[ch]    = sat_sum(acc_wms[ch], watts * ms);
        unreported[ch] = 1'b1;
      end
      // A changed total goes out on the interval, or at once when the draw falls to zero.
      if (unreported[ch] && (due || watts == 0)) begin
        batch[n].source      = SRC_W'(ch);
        batch[n].energy_wms  = acc_wms[ch];
        batch[n].last_result = 1'b0;
        n++;
        unreported[ch] = 1'b0;
      end
    end
    if (base_w != 0) begin
      sys_wms = sat_sum(sys_wms, {48'd0, base_w} * ms);
      if (due) begin
        batch[n].source      = SYSTEM_SOURCE;
        batch[n].energy_wms  = sys_wms;
        batch[n].last_result = 1'b0;
        n++;
      end
    end
    if (n > 0) begin
      batch[n-1].last_result = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      report_q.push_back(batch[i]);
    end
  endfunction

  // Word driver. A word accepted at this edge goes through the model, and
  // the next one is offered unless an idle burst is under way. An offered
  // word that is stalled is held exactly as it is.
  always @(posedge clk_i) begin
    logic taken;
    taken = in_valid && !in_stall_o;
    if (taken) begin
      integrate_word(pending_words[0]);
      void'(pending_words.pop_front());
    end
    if (in_valid && !taken) begin
      // Stalled: valid and payload stay put.
    end else if (in_gap != 0) begin
      in_gap = in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_words.size() != 0) begin
      if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
        in_gap = $urandom_range(17, 0);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_word  <= pending_words[0];
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Report monitor. Each accepted report is matched against the oldest
  // expectation; the stall line is then set for the next cycle.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (report_q.size() == 0) begin
          if (error_count < 10) begin
            $display("unexpected report: source %0d energy %h last %b",
                     out_word_o.source, out_word_o.energy_wms, out_word_o.last_result);
          end
          error_count++;
        end else begin
          want = report_q.pop_front();
          if (out_word_o.source !== want.source ||
              out_word_o.energy_wms !== want.energy_wms ||
              out_word_o.last_result !== want.last_result) begin
            if (error_count < 10) begin
              $display("mismatch: want src %0d e %h last %b, got src %0d e %h last %b",
                       want.source, want.energy_wms, want.last_result,
                       out_word_o.source, out_word_o.energy_wms, out_word_o.last_result);
            end
            error_count++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap = out_gap - 1;
        out_stall <= 1'b1;
      end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
        out_gap = $urandom_range(17, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Writes one register and mirrors it into the model. Bits above the
  // register's width carry random junk, which the block must ignore.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_DATA_W-1:0] data;
    case (idx)
      CFG_TICK_PERIOD: keep = 32'h0000_03FF;
      CFG_INTERVAL:    keep = 32'hFFFF_FFFF;
      CFG_BASELINE:    keep = 32'h0000_FFFF;
      default:         keep = 32'h0000_00FF;
    endcase
    data = (value & keep) | ($urandom & ~keep);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TICK_PERIOD: period_ms = data[PERIOD_W-1:0];
      CFG_INTERVAL:    interval  = data[TICK_W-1:0];
      CFG_BASELINE:    base_w    = data[WATT_W-1:0];
      default:         en_mask   = data[MASK_W-1:0];
    endcase
  endtask

  task automatic set_config(logic [31:0] p, logic [31:0] iv, logic [31:0] b, logic [31:0] m);
    write_reg(CFG_TICK_PERIOD, p);
    write_reg(CFG_INTERVAL, iv);
    write_reg(CFG_BASELINE, b);
    write_reg(CFG_ENABLE_MASK, m);
  endtask

  // Waits until every word is taken and every report has arrived, then lets
  // the block finish anything that causes no report.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || report_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_word(func_e f, logic [TICK_W-1:0] now, watt_vec_t p);
    in_word_t w;
    w.func       = f;
    w.tick_count = now;
    {w.power_ch7, w.power_ch6, w.power_ch5, w.power_ch4,
     w.power_ch3, w.power_ch2, w.power_ch1, w.power_ch0} = p;
    pending_words.push_back(w);
  endfunction

  // Per-channel draw: zero often, so that drop-to-zero reports occur, full
  // scale now and then. Heavy draws are used to drive the totals into saturation.
  function automatic watt_vec_t rand_watts(bit heavy);
    watt_vec_t v;
    int        r;
    for (int ch = 0; ch < CH_SLOTS; ch++) begin
      r = $urandom_range(99);
      if (heavy) begin
        v[ch] = (r < 30) ? 16'hFFFF : 16'($urandom_range(65535, 50000));
      end else if (r < 30) begin
        v[ch] = '0;
      end else if (r < 40) begin
        v[ch] = 16'hFFFF;
      end else begin
        v[ch] = 16'($urandom);
      end
    end
    return v;
  endfunction

  // Mostly a start followed by samples at advancing ticks; a few restarts
  // and samples at arbitrary tick values are mixed in as noise.
  task automatic random_phase(int count);
    logic [TICK_W-1:0] tick;
    int                r;
    tick = $urandom;
    push_word(FUNC_START, tick, rand_watts(1'b0));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        tick = $urandom;
        push_word(FUNC_START, tick, rand_watts(1'b0));
      end else if (r < 8) begin
        push_word(FUNC_SAMPLE, $urandom, rand_watts(1'b0));
      end else begin
        r = $urandom_range(99);
        if (r < 15) begin
          tick = tick;
        end else if (r < 65) begin
          tick = tick + $urandom_range(2000, 1);
        end else if (r < 90) begin
          tick = tick + $urandom_range(400000, 1);
        end else begin
          tick = tick + $urandom;
        end
        push_word(FUNC_SAMPLE, tick, rand_watts(1'b0));
      end
    end
    settle();
  endtask

  task automatic random_config();
    logic [31:0] p;
    logic [31:0] iv;
    logic [31:0] b;
    logic [31:0] m;
    case ($urandom_range(4))
      0:       p = 0;
      1:       p = 1;
      2:       p = 1000;
      3:       p = 1023;
      default: p = $urandom_range(1023);
    endcase
    case ($urandom_range(5))
      0:       iv = 0;
      1:       iv = 1;
      2:       iv = 300000;
      3:       iv = 32'hFFFF_FFFF;
      4:       iv = $urandom;
      default: iv = $urandom_range(5000, 1);
    endcase
    case ($urandom_range(2))
      0:       b = 0;
      1:       b = 16'hFFFF;
      default: b = $urandom_range(65535);
    endcase
    case ($urandom_range(3))
      0:       m = 0;
      1:       m = 8'hFF;
      default: m = $urandom_range(255);
    endcase
    set_config(p, iv, b, m);
  endtask

  initial begin
    logic [TICK_W-1:0] tick;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset register values.
    in_idle_pct  = 20;
    out_idle_pct = 20;
    // A sample before any start works from zeroed tick marks and is not yet due.
    push_word(FUNC_SAMPLE, 32'd5, {16'd7, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd300, 16'd0, 16'd100});
    // No time has passed: nothing is added, but the channels stay marked.
    push_word(FUNC_SAMPLE, 32'd5, {16'd7, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd300, 16'd0, 16'd100});
    // Channel 0 falls to zero and reports; channel 3 never drew and stays quiet.
    push_word(FUNC_SAMPLE, 32'd10, {16'd7, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd300, 16'd9, 16'd0});
    // Start just below the wrap point, then a sample past it at full scale.
    push_word(FUNC_START, 32'hFFFF_FFF0, '0);
    push_word(FUNC_SAMPLE, 32'h0000_0010, '1);
    // Small draw on every channel, not yet due: all become pending.
    push_word(FUNC_SAMPLE, 32'h0000_0011, {8{16'd1}});
    settle();

    // Interval zero makes every sample due; half the channels masked off
    // still owe their reports, so this sample gives the full nine words.
    set_config(1023, 0, 16'hFFFF, 8'h5A);
    push_word(FUNC_SAMPLE, 32'h0000_0030, '1);
    push_word(FUNC_SAMPLE, 32'hFFFF_FFFF, '0);
    push_word(FUNC_SAMPLE, 32'hFFFF_FFFF, {16'hFFFF, 16'h0, 16'hFFFF, 16'h0,
                                          16'hFFFF, 16'h0, 16'hFFFF, 16'h0});
    settle();

    // A zero tick period adds nothing, however long the gap.
    set_config(0, 32'hFFFF_FFFF, 1, 8'hFF);
    push_word(FUNC_START, 32'd0, '1);
    push_word(FUNC_SAMPLE, 32'h7FFF_FFFF, '1);
    push_word(FUNC_SAMPLE, 32'h8000_0000, '0);
    settle();

    // Every channel masked: only the system total reports.
    set_config(1000, 1, 16'hFFFF, 8'h00);
    push_word(FUNC_SAMPLE, 32'h8000_1000, {4{16'h5555, 16'hAAAA}});
    push_word(FUNC_START, 32'hFFFF_FFFF, '0);
    push_word(FUNC_SAMPLE, 32'd0, {4{16'hAAAA, 16'h5555}});
    settle();

    // Random part: a few phases, each with its own register setting and idle mix.
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 1) ? 4 : 25;
      out_idle_pct = (ph == 2) ? 3 : 30;
      random_config();
      random_phase(4);
    end

    // Final stretch, with no idling: long gaps at a tick period of 1000
    // and near full-scale draw push the system total and the busiest
    // channels into saturation.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_config(1000, 1, 16'hFFFF, 8'hFF);
    tick = $urandom;
    push_word(FUNC_START, tick, '0);
    for (int i = 0; i < 70; i++) begin
      tick = tick + 32'hFFFF_FFFF - $urandom_range(1000);
      push_word(FUNC_SAMPLE, tick, rand_watts(1'b1));
    end
    settle();

    error_count += report_q.size();
    if (error_count == 0) begin
      $display("[channel_energy_accumulator] OK");
    end else begin
      $display("[channel_energy_accumulator] ERROR");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct one.
  initial begin
    #2_000_000;
    $display("[channel_energy_accumulator] ERROR");
    $finish;
  end

endmodule
